// ----- rtl/mrlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlc_pkg
// Shared types, character constants and compare helpers for the modem
// response line classifier.
// ----------------------------------------------------------------------------
package mrlc_pkg;

   // Payload of one received item.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       rx_fault;
   } req_payload_type;

   // Payload of one result item.
   typedef struct packed {
      logic [3:0] line_code;
      logic       incoming_call;
      logic       fetch_sms;
      logic       sms_handled;
   } rsp_payload_type;

   // Compare hits for the byte at the head of the window.
   typedef struct packed {
      logic ok;
      logic ring;
      logic err_word;
      logic ati;
      logic clip;
      logic cmti;
      logic cmgr;
      logic num_a;
      logic num_b;
      logic test;
      logic red;
      logic green;
      logic blue;
   } match_hits_type;

   localparam int unsigned WIN_BYTES = 10;
   localparam int unsigned WIN_BITS  = 8 * WIN_BYTES;
   localparam int unsigned HIST_BITS = WIN_BITS - 8;
   localparam int unsigned NUM_BITS  = 4 * WIN_BYTES;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   // Words, right aligned: the newest character sits in the low byte.
   localparam logic [WIN_BITS-1:0] WORD_OK    = WIN_BITS'("OK");
   localparam logic [WIN_BITS-1:0] WORD_RING  = WIN_BITS'("RING");
   localparam logic [WIN_BITS-1:0] WORD_ERROR = WIN_BITS'("ERROR");
   localparam logic [WIN_BITS-1:0] WORD_ATI   = WIN_BITS'("ATI");
   localparam logic [WIN_BITS-1:0] WORD_CLIP  = WIN_BITS'("+CLIP:");
   localparam logic [WIN_BITS-1:0] WORD_CMTI  = WIN_BITS'("+CMTI:");
   localparam logic [WIN_BITS-1:0] WORD_CMGR  = WIN_BITS'("+CMGR:");
   localparam logic [WIN_BITS-1:0] WORD_TEST  = WIN_BITS'("Test");
   localparam logic [WIN_BITS-1:0] WORD_RED   = WIN_BITS'("Red");
   localparam logic [WIN_BITS-1:0] WORD_GREEN = WIN_BITS'("Green");
   localparam logic [WIN_BITS-1:0] WORD_BLUE  = WIN_BITS'("Blue");

   localparam logic [WIN_BITS-1:0] MASK_2 = WIN_BITS'(16'hFFFF);
   localparam logic [WIN_BITS-1:0] MASK_3 = WIN_BITS'(24'hFF_FFFF);
   localparam logic [WIN_BITS-1:0] MASK_4 = WIN_BITS'(32'hFFFF_FFFF);
   localparam logic [WIN_BITS-1:0] MASK_5 = WIN_BITS'(40'hFF_FFFF_FFFF);
   localparam logic [WIN_BITS-1:0] MASK_6 = WIN_BITS'(48'hFFFF_FFFF_FFFF);

   // Result codes.
   localparam logic [3:0] CODE_NONE  = 4'd0;
   localparam logic [3:0] CODE_OK    = 4'd1;
   localparam logic [3:0] CODE_RING  = 4'd2;
   localparam logic [3:0] CODE_ERROR = 4'd3;
   localparam logic [3:0] CODE_ATI   = 4'd4;
   localparam logic [3:0] CODE_TEST  = 4'd5;
   localparam logic [3:0] CODE_RED   = 4'd6;
   localparam logic [3:0] CODE_GREEN = 4'd7;
   localparam logic [3:0] CODE_BLUE  = 4'd8;

   // Register indexes (paddr bit 3).
   localparam logic REG_NUMBER_A = 1'b0;
   localparam logic REG_NUMBER_B = 1'b1;

   // Window ends with the masked part of the word.
   function automatic logic word_hit(input logic [WIN_BITS-1:0] win,
                                     input logic [WIN_BITS-1:0] word,
                                     input logic [WIN_BITS-1:0] mask);
      word_hit = ((win ^ word) & mask) == '0;
   endfunction

   // Window holds the ten BCD digits; nibble j pairs with window byte j.
   function automatic logic number_hit(input logic [WIN_BITS-1:0] win,
                                       input logic [NUM_BITS-1:0] num);
      logic ok;
      logic [3:0] d;
      ok = 1'b1;
      for (int j = 0; j < WIN_BYTES; j++) begin
         d = num[4*j +: 4];
         if (d > 4'd9 || win[8*j +: 8] != (CHAR_ZERO | {4'd0, d})) begin
            ok = 1'b0;
         end
      end
      number_hit = ok;
   endfunction

endpackage

// ----- rtl/mrlc_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlc_match
// Parallel compare of the byte window against the fixed words and the two
// allowed caller numbers.
// ----------------------------------------------------------------------------
module mrlc_match (
   input  logic [mrlc_pkg::WIN_BITS-1:0] win,
   input  logic [mrlc_pkg::NUM_BITS-1:0] number_a,
   input  logic [mrlc_pkg::NUM_BITS-1:0] number_b,
   output mrlc_pkg::match_hits_type      hits
);
   import mrlc_pkg::*;

   always_comb begin
      hits.ok       = word_hit(win, WORD_OK,    MASK_2);
      hits.ring     = word_hit(win, WORD_RING,  MASK_4);
      hits.err_word = word_hit(win, WORD_ERROR, MASK_5);
      hits.ati      = word_hit(win, WORD_ATI,   MASK_3);
      hits.clip     = word_hit(win, WORD_CLIP,  MASK_6);
      hits.cmti     = word_hit(win, WORD_CMTI,  MASK_6);
      hits.cmgr     = word_hit(win, WORD_CMGR,  MASK_6);
      hits.num_a    = number_hit(win, number_a);
      hits.num_b    = number_hit(win, number_b);
      hits.test     = word_hit(win, WORD_TEST,  MASK_4);
      hits.red      = word_hit(win, WORD_RED,   MASK_3);
      hits.green    = word_hit(win, WORD_GREEN, MASK_5);
      hits.blue     = word_hit(win, WORD_BLUE,  MASK_4);
   end

endmodule

// ----- rtl/modem_response_line_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_line_classifier
// Classifies modem response lines byte by byte and emits one result item per
// completed line (none for a message-read header on an allowed number).
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  rx_byte, rx_fault
//  rsp      out        rsp_valid/rsp_stall  line_code, incoming_call,
//                                           fetch_sms, sms_handled
//  csr      in/out     APB psel/penable     whitelist_number_a (0x0), _b (0x8)
//
//  One item per cycle sustained while the result side does not stall. The
//  window compare and line state update run on the item while it sits in
//  the input register, and any result lands in the output register, which
//  drives rsp_valid, once that register is free.
//  Synchronous active-high reset clears line state, held message state,
//  both numbers and both valid flags. A stalled result holds the output
//  register; the input register still takes one more item behind it.
// ----------------------------------------------------------------------------
module modem_response_line_classifier (
   input  logic                      clock,
   input  logic                      reset,
   // received bytes
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mrlc_pkg::req_payload_type req_data,
   // line results
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mrlc_pkg::rsp_payload_type rsp_data,
   // configuration
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [3:0]                paddr,
   input  logic [63:0]               pwdata,
   output logic [63:0]               prdata,
   output logic                      pready
);
   import mrlc_pkg::*;

   // configuration registers
   logic [NUM_BITS-1:0] number_a_ff, number_a_in;
   logic [NUM_BITS-1:0] number_b_ff, number_b_in;

   // input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff, in_item_in;

   // line state
   logic [HIST_BITS-1:0] recent_ff, recent_in;
   logic [8:0]           line_flags_ff, line_flags_in;
   logic [3:0]           word_flags_ff, word_flags_in;
   logic                 sms_pending_ff, sms_pending_in;
   logic [2:0]           held_code_ff, held_code_in;
   logic                 held_fetch_ff, held_fetch_in;
   logic                 held_call_ff, held_call_in;

   // output register
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff, out_item_in;

   logic           out_free;
   logic           stage_go;
   logic           req_take;
   logic           csr_write;
   match_hits_type hits;
   logic [WIN_BITS-1:0] win;

   // line flag positions
   localparam int unsigned F_OK   = 0;
   localparam int unsigned F_RING = 1;
   localparam int unsigned F_ERR  = 2;
   localparam int unsigned F_ATI  = 3;
   localparam int unsigned F_CLIP = 4;
   localparam int unsigned F_CMTI = 5;
   localparam int unsigned F_CMGR = 6;
   localparam int unsigned F_NUMA = 7;
   localparam int unsigned F_NUMB = 8;

   // ---------------------------------------------------------------------
   // Configuration port: always ready, index on paddr bit 3.
   // ---------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[3] == REG_NUMBER_B) ? 64'(number_b_ff) : 64'(number_a_ff);

   always_comb begin
      number_a_in = number_a_ff;
      number_b_in = number_b_ff;
      if (csr_write) begin
         unique case (paddr[3])
            REG_NUMBER_A: number_a_in = pwdata[NUM_BITS-1:0];
            REG_NUMBER_B: number_b_in = pwdata[NUM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshakes. The stage advances whenever the output register is free
   // or drains this cycle; the input register refills behind it.
   // ---------------------------------------------------------------------
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign stage_go  = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_item_in  = req_data;
         in_valid_in = 1'b1;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Window compare: current byte in the low byte, older bytes above.
   // ---------------------------------------------------------------------
   assign win = {recent_ff, in_item_ff.rx_byte};

   mrlc_match u_match (
      .win      (win),
      .number_a (number_a_ff),
      .number_b (number_b_ff),
      .hits     (hits)
   );

   // ---------------------------------------------------------------------
   // Line state and result formation.
   // ---------------------------------------------------------------------
   always_comb begin
      logic [3:0] code;
      logic       num;
      logic       call;
      logic       fetch;

      recent_in      = recent_ff;
      line_flags_in  = line_flags_ff;
      word_flags_in  = word_flags_ff;
      sms_pending_in = sms_pending_ff;
      held_code_in   = held_code_ff;
      held_fetch_in  = held_fetch_ff;
      held_call_in   = held_call_ff;
      out_item_in    = out_item_ff;
      out_valid_in   = out_valid_ff && rsp_stall;

      // status code by priority
      if (line_flags_ff[F_OK]) begin
         code = CODE_OK;
      end else if (line_flags_ff[F_RING]) begin
         code = CODE_RING;
      end else if (line_flags_ff[F_ERR]) begin
         code = CODE_ERROR;
      end else if (line_flags_ff[F_ATI]) begin
         code = CODE_ATI;
      end else begin
         code = CODE_NONE;
      end
      num   = line_flags_ff[F_NUMA] || line_flags_ff[F_NUMB];
      call  = num && line_flags_ff[F_CLIP];
      fetch = line_flags_ff[F_CMTI];

      if (stage_go && !in_item_ff.rx_fault && in_item_ff.rx_byte != CHAR_LF) begin
         if (in_item_ff.rx_byte == CHAR_CR) begin
            // line end: clear the line, then emit or hold
            recent_in     = '0;
            line_flags_in = '0;
            word_flags_in = '0;
            if (sms_pending_ff) begin
               // message text: last word in Test, Red, Green, Blue order wins
               if (word_flags_ff[3]) begin
                  out_item_in.line_code = CODE_BLUE;
               end else if (word_flags_ff[2]) begin
                  out_item_in.line_code = CODE_GREEN;
               end else if (word_flags_ff[1]) begin
                  out_item_in.line_code = CODE_RED;
               end else if (word_flags_ff[0]) begin
                  out_item_in.line_code = CODE_TEST;
               end else begin
                  out_item_in.line_code = {1'b0, held_code_ff};
               end
               out_item_in.incoming_call = held_call_ff;
               out_item_in.fetch_sms     = held_fetch_ff;
               out_item_in.sms_handled   = 1'b1;
               out_valid_in   = 1'b1;
               sms_pending_in = 1'b0;
               held_code_in   = '0;
               held_fetch_in  = 1'b0;
               held_call_in   = 1'b0;
            end else if (num && line_flags_ff[F_CMGR]) begin
               // message header on an allowed number: hold, no result
               sms_pending_in = 1'b1;
               held_code_in   = code[2:0];
               held_fetch_in  = fetch;
               held_call_in   = call;
            end else begin
               out_item_in.line_code     = code;
               out_item_in.incoming_call = call;
               out_item_in.fetch_sms     = fetch;
               out_item_in.sms_handled   = 1'b0;
               out_valid_in              = 1'b1;
            end
         end else begin
            // line content: set sticky flags and advance the window
            line_flags_in[F_OK]   = line_flags_ff[F_OK]   | hits.ok;
            line_flags_in[F_RING] = line_flags_ff[F_RING] | hits.ring;
            line_flags_in[F_ERR]  = line_flags_ff[F_ERR]  | hits.err_word;
            line_flags_in[F_ATI]  = line_flags_ff[F_ATI]  | hits.ati;
            line_flags_in[F_CLIP] = line_flags_ff[F_CLIP] | hits.clip;
            line_flags_in[F_CMTI] = line_flags_ff[F_CMTI] | hits.cmti;
            line_flags_in[F_CMGR] = line_flags_ff[F_CMGR] | hits.cmgr;
            line_flags_in[F_NUMA] = line_flags_ff[F_NUMA] | hits.num_a;
            line_flags_in[F_NUMB] = line_flags_ff[F_NUMB] | hits.num_b;
            if (sms_pending_ff) begin
               word_flags_in = word_flags_ff |
                               {hits.blue, hits.green, hits.red, hits.test};
            end
            recent_in = {recent_ff[HIST_BITS-9:0], in_item_ff.rx_byte};
         end
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         number_a_ff    <= '0;
         number_b_ff    <= '0;
         in_valid_ff    <= 1'b0;
         recent_ff      <= '0;
         line_flags_ff  <= '0;
         word_flags_ff  <= '0;
         sms_pending_ff <= 1'b0;
         held_code_ff   <= '0;
         held_fetch_ff  <= 1'b0;
         held_call_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         number_a_ff    <= number_a_in;
         number_b_ff    <= number_b_in;
         in_valid_ff    <= in_valid_in;
         recent_ff      <= recent_in;
         line_flags_ff  <= line_flags_in;
         word_flags_ff  <= word_flags_in;
         sms_pending_ff <= sms_pending_in;
         held_code_ff   <= held_code_in;
         held_fetch_ff  <= held_fetch_in;
         held_call_ff   <= held_call_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

endmodule

// ----- rtl/mrlc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrlc_checker
// Port-level checks for the modem response line classifier.
// ----------------------------------------------------------------------------
module mrlc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input mrlc_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input mrlc_pkg::rsp_payload_type rsp_data,
   input logic                      pready
);
   import mrlc_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("mrlc: stalled result changed or dropped");

   // plain lines only carry status codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.sms_handled |->
         rsp_data.line_code == CODE_NONE || rsp_data.line_code == CODE_OK ||
         rsp_data.line_code == CODE_RING || rsp_data.line_code == CODE_ERROR ||
         rsp_data.line_code == CODE_ATI)
      else $error("mrlc: message code on a plain line result");

   // a new result follows an accepted item
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("mrlc: result without an item");

   // only a line end can raise a result
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_data.rx_byte == CHAR_CR && !req_data.rx_fault, 2))
      else $error("mrlc: result not caused by a line end");

   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("mrlc: configuration port not ready");

endmodule

bind modem_response_line_classifier mrlc_checker u_mrlc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

// ----- sim/tb_modem_response_line_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modem_response_line_classifier
// Feeds received modem bytes line by line, first from a short table of
// hand-picked lines, then as random lines built from status words, caller
// numbers, message headers and noise. A local line classifier, or the table row
// where one is given, predicts the result of every completed line; each result item is checked in order.
// ----------------------------------------------------------------------------
module tb_modem_response_line_classifier;
   import mrlc_pkg::*;

   localparam int DIR_ROWS    = 25;
   localparam int DIR_CFG_ROW = 17;   // numbers get programmed before this row
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 40;
   localparam int SETTLE      = 4;    // margin for the pipe to settle

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [3:0]      paddr;
   logic [63:0]     pwdata;
   logic [63:0]     prdata;
   logic            pready;

   modem_response_line_classifier uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Fragments for random lines; the last four only count inside message text.
   string key_words [11] = '{"OK", "RING", "ERROR", "ATI", "+CLIP:", "+CMTI:", "+CMGR:",
                             "Test", "Red", "Green", "Blue"};

   // Classifier state mirrored by the testbench.
   logic [39:0]     allowed_a;
   logic [39:0]     allowed_b;
   logic [7:0]      line_tail [9];   // previous bytes of the line, newest first
   match_hits_type  seen;            // sticky hits of the current line
   logic            text_line_next;  // next line is the message body
   rsp_payload_type held;            // flags of the message header line

   rsp_payload_type awaited_results [$];
   logic            listed_armed;    // table row supplies the expected result
   rsp_payload_type listed_want;
   int              error_count;
   int              fed_items;
   logic            gaps_on;

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Line classifier prediction
   // ---------------------------------------------------------------------

   // Word ends with the current byte, preceded by the line tail.
   function automatic logic tail_matches(input string w, input logic [7:0] cur);
      int   n;
      logic hit;
      n   = w.len();
      hit = (8'(w[n-1]) == cur);
      for (int i = 1; i < n; i++) begin
         if (8'(w[n-1-i]) != line_tail[i-1]) hit = 1'b0;
      end
      return hit;
   endfunction

   // Ten BCD digits end with the current byte; lowest nibble is the newest byte.
   function automatic logic number_matches(input logic [39:0] num, input logic [7:0] cur);
      logic       hit;
      logic [3:0] digit;
      logic [7:0] ch;
      hit = 1'b1;
      for (int j = 0; j < 10; j++) begin
         digit = num[4*j +: 4];
         ch    = (j == 0) ? cur : line_tail[j-1];
         if (digit > 4'd9 || ch != {4'h3, digit}) hit = 1'b0;
      end
      return hit;
   endfunction

   function automatic void clear_line_state();
      foreach (line_tail[i]) line_tail[i] = 8'h00;
      seen = '0;
   endfunction

   // Advance the classifier by one accepted byte; return 1 with the result
   // when the byte ends a line that produces one.
   function automatic logic classify_byte(input logic [7:0] b, input logic faulted,
                                          output rsp_payload_type r);
      logic [3:0] code;
      logic       num;
      logic       call;
      logic       fetch;
      r = '0;
      if (faulted || b == CHAR_LF) return 1'b0;

      if (b == CHAR_CR) begin
         // Message body: held header flags, code overridden by the last word
         // in the order Test, Red, Green, Blue.
         if (text_line_next) begin
            code = held.line_code;
            if (seen.blue)       code = CODE_BLUE;
            else if (seen.green) code = CODE_GREEN;
            else if (seen.red)   code = CODE_RED;
            else if (seen.test)  code = CODE_TEST;
            r = '{code, held.incoming_call, held.fetch_sms, 1'b1};
            text_line_next = 1'b0;
            held           = '0;
            clear_line_state();
            return 1'b1;
         end
         code = seen.ok       ? CODE_OK    :
                seen.ring     ? CODE_RING  :
                seen.err_word ? CODE_ERROR :
                seen.ati      ? CODE_ATI   : CODE_NONE;
         num   = seen.num_a | seen.num_b;
         call  = num & seen.clip;
         fetch = seen.cmti;
         r = '{code, call, fetch, 1'b0};
         // Header of a message from an allowed number: hold and emit nothing.
         if (num && seen.cmgr) begin
            text_line_next = 1'b1;
            held           = r;
            clear_line_state();
            return 1'b0;
         end
         clear_line_state();
         return 1'b1;
      end

      seen.ok       = seen.ok       | tail_matches("OK", b);
      seen.ring     = seen.ring     | tail_matches("RING", b);
      seen.err_word = seen.err_word | tail_matches("ERROR", b);
      seen.ati      = seen.ati      | tail_matches("ATI", b);
      seen.clip     = seen.clip     | tail_matches("+CLIP:", b);
      seen.cmti     = seen.cmti     | tail_matches("+CMTI:", b);
      seen.cmgr     = seen.cmgr     | tail_matches("+CMGR:", b);
      seen.num_a    = seen.num_a    | number_matches(allowed_a, b);
      seen.num_b    = seen.num_b    | number_matches(allowed_b, b);
      if (text_line_next) begin
         seen.test  = seen.test  | tail_matches("Test", b);
         seen.red   = seen.red   | tail_matches("Red", b);
         seen.green = seen.green | tail_matches("Green", b);
         seen.blue  = seen.blue  | tail_matches("Blue", b);
      end
      for (int i = 8; i > 0; i--) line_tail[i] = line_tail[i-1];
      line_tail[0] = b;
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Result monitor: check every accepted result against the oldest
   // expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, actual code %0d call %0b fetch %0b handled %0b",
                     $time, rsp_data.line_code, rsp_data.incoming_call,
                     rsp_data.fetch_sms, rsp_data.sms_handled);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.line_code !== want.line_code
                || rsp_data.incoming_call !== want.incoming_call
                || rsp_data.fetch_sms !== want.fetch_sms
                || rsp_data.sms_handled !== want.sms_handled) begin
               error_count++;
               $display("%0t: mismatch: expected code %0d call %0b fetch %0b handled %0b,",
                        $time, want.line_code, want.incoming_call, want.fetch_sms,
                        want.sms_handled);
               $display("%0t:           actual   code %0d call %0b fetch %0b handled %0b",
                        $time, rsp_data.line_code, rsp_data.incoming_call,
                        rsp_data.fetch_sms, rsp_data.sms_handled);
            end
         end
      end
   end

   // Receiver back-pressure: stall at random, with a chance of 15 percent, while gaps are on.
   always @(negedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(0, 99) < 15);
   end

   // ---------------------------------------------------------------------
   // Drivers; every task starts and ends at a falling edge.
   // ---------------------------------------------------------------------

   // Offer one item, hold it until accepted, then predict its result.
   task automatic send_byte(input logic [7:0] value, input logic faulted);
      rsp_payload_type outcome;
      logic            produced;
      while (gaps_on && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: value, rx_fault: faulted};
      do @(posedge clock); while (req_stall);
      produced = classify_byte(value, faulted, outcome);
      if (produced) awaited_results.push_back(listed_armed ? listed_want : outcome);
      listed_armed = 1'b0;
      if (!faulted && value != CHAR_LF) fed_items++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), 1'b0);
   endtask

   // Send one of the allowed numbers as digits, sometimes with one digit bent.
   task automatic send_number_text();
      string s;
      s = $sformatf("%010h", $urandom_range(0, 1) ? allowed_a : allowed_b);
      if ($urandom_range(0, 99) < 25) begin
         s.putc($urandom_range(0, 9), 8'($urandom_range(8'h30, 8'h39)));
      end
      send_text(s);
   endtask

   // Drop valid and wait until every result is in and the pipe has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // Write a number register, read it back, and update the local copy.
   task automatic write_number(input logic which, input logic [39:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 3'b000};
      pwdata  <= {24'($urandom()), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[39:0] !== value) begin
         error_count++;
         $display("%0t: register %0d read back: expected %h actual %h",
                  $time, which, value, prdata[39:0]);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (which == REG_NUMBER_A) allowed_a = value;
      else                       allowed_b = value;
      @(negedge clock);
   endtask

   function automatic logic [39:0] random_bcd();
      logic [39:0] n;
      for (int j = 0; j < 10; j++) n[4*j +: 4] = 4'($urandom_range(0, 9));
      return n;
   endfunction

   // One random line ending in CR: status words, numbers, printable text,
   // raw noise, faulted bytes and LF, sometimes after a long run of filler.
   task automatic random_line(input logic message_text);
      int pick;
      int parts;
      int idx;
      parts = $urandom_range(0, 5);
      if ($urandom_range(0, 99) < 4) begin
         repeat ($urandom_range(30, 60)) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
      end
      repeat (parts) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            idx = (message_text && $urandom_range(0, 1)) ? $urandom_range(7, 10)
                                                         : $urandom_range(0, 10);
            send_text(key_words[idx]);
         end else if (pick < 45) begin
            send_number_text();
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         end else if (pick < 85) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 92) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
         end else begin
            send_byte(CHAR_LF, 1'b0);
         end
      end
      send_byte(CHAR_CR, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      string           text;
      int              fault_at;
      logic            typed;
      rsp_payload_type want;
      logic [7:0]      ch;
      logic [39:0]     num_a;
      logic [39:0]     num_b;
      int              phase_start;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      gaps_on        = 1'b1;
      error_count    = 0;
      fed_items      = 0;
      listed_armed   = 1'b0;
      listed_want    = '0;
      allowed_a      = '0;
      allowed_b      = '0;
      text_line_next = 1'b0;
      held           = '0;
      clear_line_state();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. Numbers are still at their reset value of all zero
      // digits until the configuration row. A SOH byte in a row's text is
      // sent as NUL, which a string cannot hold.
      for (int k = 0; k < DIR_ROWS; k++) begin
         fault_at = -1;
         typed    = 1'b0;
         want     = '0;
         case (k)
            0:  begin text = "";      typed = 1'b1; want = '{CODE_NONE, 1'b0, 1'b0, 1'b0}; end
            1:  begin text = "OK";    typed = 1'b1; want = '{CODE_OK, 1'b0, 1'b0, 1'b0}; end
            2:  begin text = "RING";  typed = 1'b1; want = '{CODE_RING, 1'b0, 1'b0, 1'b0}; end
            3:  begin text = "ERROR"; typed = 1'b1; want = '{CODE_ERROR, 1'b0, 1'b0, 1'b0}; end
            4:  begin text = "ATI";   typed = 1'b1; want = '{CODE_ATI, 1'b0, 1'b0, 1'b0}; end
            // priority: OK wins over everything else in the line
            5:  begin text = "ATI ERROR RING OK";
                      typed = 1'b1; want = '{CODE_OK, 1'b0, 1'b0, 1'b0}; end
            // leading LF and a faulted byte between O and K are both dropped
            6:  begin text = "\nOXK"; fault_at = 2;
                      typed = 1'b1; want = '{CODE_OK, 1'b0, 1'b0, 1'b0}; end
            7:  text = "+CLIP: \"0000000000\",129";
            8:  text = "+CMTI: \"SM\",3";
            // header on an allowed number, then a body with several words
            9:  text = "+CMGR: \"REC UNREAD\",\"0000000000\"";
            10: text = "Red Green Test";
            // body without a message word keeps the held code
            11: text = "+CMGR: 0000000000 OK";
            12: text = "hello";
            // empty body line
            13: text = "+CMGR: +CMTI: 0000000000";
            14: text = "";
            // message words outside a body mean nothing
            15: begin text = "Blue Test"; typed = 1'b1; want = '{CODE_NONE, 1'b0, 1'b0, 1'b0}; end
            16: begin text = "\377\001AT\377";
                      typed = 1'b1; want = '{CODE_NONE, 1'b0, 1'b0, 1'b0}; end
            17: text = "+CLIP: \"0123456789\"";
            // number b holds a non-digit nibble and can never match
            18: text = "+CLIP: \"98765432a1\"";
            19: text = "+CMGR: 98765432a1";
            20: text = "+CMGR: \"0123456789\",RING";
            21: text = "Blue Test Red Green";
            // long line: matching only needs the tail of the line
            22: text = "+CLIP: ........................................ 0123456789 zz OK";
            23: text = "ERR\nOR";
            default: begin text = "RINXG"; fault_at = 3; end
         endcase
         if (k == DIR_CFG_ROW) begin
            drain();
            write_number(REG_NUMBER_A, 40'h01_2345_6789);
            write_number(REG_NUMBER_B, 40'h98_7654_32A1);
         end
         for (int i = 0; i < text.len(); i++) begin
            ch = 8'(text[i]);
            if (ch == 8'h01) ch = 8'h00;
            send_byte(ch, i == fault_at);
         end
         listed_armed = typed;
         listed_want  = want;
         send_byte(CHAR_CR, 1'b0);
      end

      // Random phases, each under its own pair of numbers. The first phase
      // runs without any idle or stall cycles.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0: begin num_a = random_bcd();     num_b = random_bcd();       end
            1: begin num_a = 40'h00_0000_0000; num_b = 40'h99_9999_9999;   end
            2: begin num_a = 40'hFF_FFFF_FFFF; num_b = random_bcd();       end
            3: begin num_a = 40'({$urandom(), $urandom()}); num_b = random_bcd(); end
            4: begin num_a = random_bcd();     num_b = num_a;              end
            default: begin num_a = random_bcd(); num_b = 40'h00_0000_0000; end
         endcase
         write_number(REG_NUMBER_A, num_a);
         write_number(REG_NUMBER_B, num_b);
         gaps_on     = (phase != 0);
         phase_start = fed_items;
         while (fed_items - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 25) begin
               // message header, then its body
               send_text("+CMGR: \"REC UNREAD\",\"");
               send_number_text();
               send_text("\"");
               random_line(1'b0);
               random_line(1'b1);
            end else begin
               random_line(1'b0);
            end
         end
      end

      drain();
      if (error_count == 0) begin
         $display("tb_modem_response_line_classifier OK");
      end else begin
         $display("tb_modem_response_line_classifier NOT OK");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("tb_modem_response_line_classifier NOT OK");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mrlc_pkg.sv
rtl/mrlc_match.sv
rtl/modem_response_line_classifier.sv
rtl/mrlc_checker.sv
sim/tb_modem_response_line_classifier.sv
